@@ hw/rtl/slist_pkg.sv @@
// ----------------------------------------------------------------------------
// slist_pkg: shared types and codes of the sequential list engine
// Request codes, field widths and the control word sent to every list cell.
// ----------------------------------------------------------------------------
package slist_pkg;

  localparam int IdxW  = 5;
  localparam int ValW  = 32;
  localparam int PosW  = 4;
  localparam int LenW  = 5;
  localparam int OpW   = 3;

  localparam logic [OpW-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OpW-1:0] OP_READ   = 3'd1;
  localparam logic [OpW-1:0] OP_LOCATE = 3'd2;
  localparam logic [OpW-1:0] OP_PREV   = 3'd3;
  localparam logic [OpW-1:0] OP_NEXT   = 3'd4;
  localparam logic [OpW-1:0] OP_INSERT = 3'd5;
  localparam logic [OpW-1:0] OP_DELETE = 3'd6;

  // Control word broadcast to the cell row.
  typedef struct packed {
    logic            ins;  // open a gap at pos and load the new value there
    logic            del;  // close the gap at pos
    logic [IdxW-1:0] pos;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/sequential_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// sequential_list_engine_top: ordered list of signed 32-bit values
// A result is registered on out_* once its request has passed the compare,
// first-match and select/commit steps. A new request is taken only after the
// last one commits, and commit waits while an earlier result is not taken.
// Reset (synchronous, rst_n low) empties the list and drops any pending
// result; entry contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module sequential_list_engine_top
  import slist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[2:0], index[7:3], value[39:8]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // ok[0], data_out[32:1], position[36:33],
                                  // length[41:37], empty_res[42], zero pad
);

  // Count must be able to hold CAPACITY itself; comparisons against the
  // 5-bit index are done at the wider of the two widths.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > IdxW) ? CW : IdxW;

  // Each request passes through compare, first-match and select/commit.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_FND  = 2'd2;
  localparam logic [1:0] S_RES  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;

  logic [OpW-1:0]         op_r;
  logic [IdxW-1:0]        idx_r;
  logic signed [ValW-1:0] val_r;

  logic [CAPACITY-1:0]    match_r;
  logic [CAPACITY-1:0]    first_r;
  logic                   found_r;

  logic signed [ValW-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]    eq_w;
  logic [CAPACITY-1:0]    live_w;   // cell lies below the current length
  logic [CAPACITY-1:0]    at_idx_w; // cell sits at the request's index
  logic [CAPACITY-1:0]    has_nx_w; // cell has a live right neighbor

  cell_ctrl_t             ctrl;

  logic                   out_tvalid_r;
  logic                   ok_r, ok_nxt;
  logic signed [ValW-1:0] data_r, data_nxt;
  logic [PosW-1:0]        pos_r, pos_nxt;
  logic [LenW-1:0]        len_r;
  logic                   empty_r;

  logic [XW-1:0]          idx_x;
  logic [XW-1:0]          cnt_x;
  logic                   in_range;
  logic                   ins_ok;
  logic                   out_free;
  logic                   commit;

  logic signed [ValW-1:0] at_val;
  logic signed [ValW-1:0] prev_val;
  logic signed [ValW-1:0] next_val;
  logic [PosW-1:0]        first_pos;
  logic                   next_ok;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;
  assign commit    = (state_r == S_RES) && out_free;

  assign idx_x    = XW'(idx_r);
  assign cnt_x    = XW'(count_r);
  assign in_range = (idx_x < cnt_x);
  assign ins_ok   = (idx_x <= cnt_x) && (count_r < CW'(CAPACITY));

  // Only the commit cycle moves entries, so every earlier step sees the
  // list exactly as it stood when the request arrived.
  assign ctrl.ins = commit && (op_r == OP_INSERT) && ins_ok;
  assign ctrl.del = commit && (op_r == OP_DELETE) && in_range;
  assign ctrl.pos = idx_r;

  // Row of cells; each one hands its entry to both neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValW-1:0] left_v;
    logic signed [ValW-1:0] right_v;

    if (i == 0) begin : g_head
      assign left_v = val_r;
    end else begin : g_body_l
      assign left_v = entry_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = entry_w[i];
    end else begin : g_body_r
      assign right_v = entry_w[i+1];
    end

    slist_cell #(
      .POS (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_val  (left_v),
      .right_val (right_v),
      .new_val   (val_r),
      .key       (val_r),
      .entry     (entry_w[i]),
      .eq        (eq_w[i])
    );

    assign live_w[i]   = (CW'(i) < count_r);
    assign at_idx_w[i] = (XW'(i) == idx_x);
    assign has_nx_w[i] = (CW'(i + 1) < count_r);
  end

  // Select paths: every vector steering them is one-hot or zero, so an
  // AND-OR over the row picks the wanted entry.
  always_comb begin
    at_val    = '0;
    prev_val  = '0;
    next_val  = '0;
    first_pos = '0;
    next_ok   = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (at_idx_w[i]) begin
        at_val = at_val | entry_w[i];
      end
      if (first_r[i]) begin
        first_pos = first_pos | PosW'(i);
        if (i > 0) begin
          prev_val = prev_val | entry_w[(i > 0) ? i - 1 : 0];
        end
        if (has_nx_w[i]) begin
          next_ok  = 1'b1;
          next_val = next_val | entry_w[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Result and new length for the request in its commit cycle.
  always_comb begin
    ok_nxt    = 1'b0;
    data_nxt  = '0;
    pos_nxt   = '0;
    count_nxt = count_r;
    unique case (op_r)
      OP_CLEAR: begin
        ok_nxt    = 1'b1;
        count_nxt = '0;
      end
      OP_READ: begin
        ok_nxt   = in_range;
        data_nxt = in_range ? at_val : '0;
      end
      OP_LOCATE: begin
        ok_nxt  = found_r;
        pos_nxt = first_pos;
      end
      OP_PREV: begin
        ok_nxt   = found_r && !first_r[0];
        data_nxt = prev_val;
      end
      OP_NEXT: begin
        ok_nxt   = next_ok;
        data_nxt = next_val;
      end
      OP_INSERT: begin
        ok_nxt = ins_ok;
        if (ins_ok) begin
          count_nxt = count_r + CW'(1);
        end
      end
      OP_DELETE: begin
        ok_nxt   = in_range;
        data_nxt = in_range ? at_val : '0;
        if (in_range) begin
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // Control sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_FND;
      end
      S_FND: begin
        state_nxt = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Request hold, match vector and first-match one-hot.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_tdata[2:0];
      idx_r <= in_tdata[7:3];
      val_r <= in_tdata[39:8];
    end
    if (state_r == S_CMP) begin
      match_r <= eq_w & live_w;
    end
    if (state_r == S_FND) begin
      first_r <= match_r & (~match_r + CAPACITY'(1));
      found_r <= |match_r;
    end
  end

  // Output register; it frees the request side while a result waits.
  always_ff @(posedge clk) begin
    if (commit) begin
      ok_r    <= ok_nxt;
      data_r  <= data_nxt;
      pos_r   <= pos_nxt;
      len_r   <= LenW'(count_nxt);
      empty_r <= (count_nxt == '0);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, empty_r, len_r, pos_r, data_r, ok_r};

endmodule

@@ hw/rtl/slist_cell.sv @@
// ----------------------------------------------------------------------------
// slist_cell: one list entry
// Holds one value, takes its left neighbor or the new value on insert, takes
// its right neighbor on delete, and compares its value against the search key.
// ----------------------------------------------------------------------------
module slist_cell
  import slist_pkg::*;
#(
  parameter int POS = 0
) (
  input  logic                   clk,
  input  cell_ctrl_t             ctrl,
  input  logic signed [ValW-1:0] left_val,
  input  logic signed [ValW-1:0] right_val,
  input  logic signed [ValW-1:0] new_val,
  input  logic signed [ValW-1:0] key,
  output logic signed [ValW-1:0] entry,
  output logic                   eq
);

  logic signed [ValW-1:0] entry_r;
  logic signed [ValW-1:0] entry_nxt;
  logic                   above;
  logic                   at;

  assign above = (POS > int'(ctrl.pos));
  assign at    = (POS == int'(ctrl.pos));

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (above) begin
        entry_nxt = left_val;
      end else if (at) begin
        entry_nxt = new_val;
      end
    end else if (ctrl.del && (above || at)) begin
      entry_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign eq    = (entry_r == key);

endmodule

@@ dv/slist_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slist_checker: result predictor and comparator for the list engine
// Keeps a private copy of the list, works out the answer to every accepted
// request and compares each returned result, field by field, in order.
// ----------------------------------------------------------------------------
module slist_checker
  import slist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // op[2:0], index[7:3], value[39:8]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // ok[0], data_out[32:1], position[36:33],
                                  // length[41:37], empty_res[42], zero pad
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic                   ok;
    logic signed [ValW-1:0] data;
    logic [PosW-1:0]        pos;
    logic [LenW-1:0]        len;
    logic                   empty;
  } list_result_t;

  logic [ValW-1:0] cells [CAPACITY];
  int              list_len;
  list_result_t    pending_results[$];

  // Applies one request to the private list and returns its answer.
  function automatic list_result_t apply_list_request(
    input logic [OpW-1:0]  op,
    input logic [IdxW-1:0] idx,
    input logic [ValW-1:0] val
  );
    list_result_t r;
    int           hit;
    int           j;
    r   = '0;
    hit = -1;
    for (j = 0; j < list_len; j++) begin
      if (hit < 0 && cells[j] == val) hit = j;
    end
    case (op)
      OP_CLEAR: begin
        list_len = 0;
        r.ok     = 1'b1;
      end
      OP_READ: begin
        if (idx < list_len) begin
          r.data = cells[idx];
          r.ok   = 1'b1;
        end
      end
      OP_LOCATE: begin
        if (hit >= 0) begin
          r.pos = hit[PosW-1:0];
          r.ok  = 1'b1;
        end
      end
      OP_PREV: begin
        if (hit > 0) begin
          r.data = cells[hit-1];
          r.ok   = 1'b1;
        end
      end
      OP_NEXT: begin
        if (hit >= 0 && hit + 1 < list_len) begin
          r.data = cells[hit+1];
          r.ok   = 1'b1;
        end
      end
      OP_INSERT: begin
        if (idx <= list_len && list_len < CAPACITY) begin
          for (j = list_len; j > idx; j--) cells[j] = cells[j-1];
          cells[idx] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (idx < list_len) begin
          r.data = cells[idx];
          for (j = idx; j + 1 < list_len; j++) cells[j] = cells[j+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.len   = list_len[LenW-1:0];
    r.empty = (list_len == 0);
    return r;
  endfunction

  initial begin
    errors   = 0;
    pending  = 0;
    list_len = 0;
  end

  // Handshake signals are stable at the falling edge, so both channels are
  // sampled there; a transfer seen here completes at the next rising edge.
  always @(negedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst_n) begin
      list_len = 0;
      pending_results.delete();
    end else begin
      // Results first: a result never belongs to a request taken in the
      // same cycle.
      if (out_tvalid && out_tready) begin
        got.ok    = out_tdata[0];
        got.data  = out_tdata[32:1];
        got.pos   = out_tdata[36:33];
        got.len   = out_tdata[41:37];
        got.empty = out_tdata[42];
        if (pending_results.size() == 0) begin
          $error("result returned with no request outstanding");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            errors++;
          end
          if (got.data !== want.data) begin
            $error("data_out: expected %0d, got %0d", want.data, got.data);
            errors++;
          end
          if (got.pos !== want.pos) begin
            $error("position: expected %0d, got %0d", want.pos, got.pos);
            errors++;
          end
          if (got.len !== want.len) begin
            $error("length: expected %0d, got %0d", want.len, got.len);
            errors++;
          end
          if (got.empty !== want.empty) begin
            $error("empty_res: expected %0d, got %0d", want.empty, got.empty);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(
          apply_list_request(in_tdata[2:0], in_tdata[7:3], in_tdata[39:8]));
      end
    end
    pending = pending_results.size();
  end

endmodule

@@ dv/tb_sequential_list_engine_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sequential_list_engine_top: stimulus and verdict for the list engine
// Sends a directed set of list requests followed by random bursts that grow,
// shrink and churn the list, with random gaps on both channels. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sequential_list_engine_top;
  import slist_pkg::*;

  localparam int              LIST_DEPTH     = 16;
  localparam int              WATCHDOG_LIMIT = 2000;
  localparam logic [OpW-1:0]  OP_UNUSED      = 3'd7;
  localparam logic [ValW-1:0] VAL_MIN        = 32'h8000_0000;
  localparam logic [ValW-1:0] VAL_MAX        = 32'h7fff_ffff;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // op[2:0], index[7:3], value[39:8]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;   // ok[0], data_out[32:1], position[36:33],
                            // length[41:37], empty_res[42], zero pad
  int          errors;
  int          pending;

  // Stimulus-side bookkeeping. The list length and recently inserted values are
  // tracked here to aim indexes and pick keys; the checker owns the contents.
  int              fill_level;
  logic [ValW-1:0] seen_values[$];
  bit              quiet;
  int              stall_cycles;

  sequential_list_engine_top #(.CAPACITY(LIST_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  slist_checker #(.CAPACITY(LIST_DEPTH)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Sends one request. Called at a rising edge; returns at the rising edge on
  // which the request was accepted. The ready check is made at the falling
  // edge, where both handshake signals are settled.
  task automatic send_request(input logic [OpW-1:0]  op,
                              input logic [IdxW-1:0] idx,
                              input logic [ValW-1:0] val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {val, idx, op};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    // Follow the list length so later indexes land near the live range.
    case (op)
      OP_CLEAR:  fill_level = 0;
      OP_INSERT: begin
        if (idx <= fill_level && fill_level < LIST_DEPTH) begin
          fill_level++;
          seen_values.push_back(val);
          if (seen_values.size() > 24) void'(seen_values.pop_front());
        end
      end
      OP_DELETE: begin
        if (idx < fill_level) fill_level--;
      end
      default: ;
    endcase
  endtask

  // Holds off the sender until every outstanding result has been returned.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // Search keys mostly come from values already stored, so hits are common.
  function automatic logic [ValW-1:0] pick_key();
    if (seen_values.size() > 0 && $urandom_range(0, 3) != 0)
      return seen_values[$urandom_range(0, seen_values.size() - 1)];
    return $urandom;
  endfunction

  // Insert values mix stored values (duplicates), extremes, tiny values that
  // collide easily, and fully random words.
  function automatic logic [ValW-1:0] pick_insert_value();
    int k;
    k = $urandom_range(0, 9);
    if (k < 2 && seen_values.size() > 0)
      return seen_values[$urandom_range(0, seen_values.size() - 1)];
    if (k == 2) return VAL_MIN;
    if (k == 3) return VAL_MAX;
    if (k == 4) return $urandom_range(0, 3);
    return $urandom;
  endfunction

  // One random burst; grow_pct and shrink_pct weight inserts and deletes.
  task automatic run_burst(input int grow_pct, input int shrink_pct, input int n);
    int              r;
    int              r2;
    logic [OpW-1:0]  op;
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] val;
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(0, 99);
      r2 = $urandom_range(0, 99);
      if (r < 2)                            op = OP_CLEAR;
      else if (r < 4)                       op = OP_UNUSED;
      else if (r < 4 + grow_pct)            op = OP_INSERT;
      else if (r < 4 + grow_pct + shrink_pct) op = OP_DELETE;
      else begin
        case (r % 4)
          0:       op = OP_READ;
          1:       op = OP_LOCATE;
          2:       op = OP_PREV;
          default: op = OP_NEXT;
        endcase
      end
      // Mostly in range, sometimes just past the end, now and then anywhere.
      if (r2 < 10)
        idx = IdxW'($urandom_range(0, 31));
      else if (op == OP_INSERT)
        idx = IdxW'($urandom_range(0, fill_level));
      else if (r2 < 20)
        idx = IdxW'(fill_level);
      else
        idx = IdxW'($urandom_range(0, (fill_level > 0) ? fill_level - 1 : 0));
      val = (op == OP_INSERT) ? pick_insert_value() : pick_key();
      send_request(op, idx, val);
    end
  endtask

  // Result side: a random stall before each result, none in quiet bursts.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
      while (!out_tvalid) @(negedge clk);
      @(posedge clk);
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  initial stall_cycles = 0;
  always @(negedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int kind;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    fill_level = 0;
    quiet      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: requests on an empty list, then a small list holding
    // both extremes, zero and minus one.
    send_request(OP_READ,   0, 0);         // read from an empty list
    send_request(OP_DELETE, 0, 0);         // delete from an empty list
    send_request(OP_LOCATE, 0, 0);         // nothing to find
    send_request(OP_PREV,   0, 0);
    send_request(OP_NEXT,   0, 0);
    send_request(OP_INSERT, 1, 5);         // insert past the end is refused
    send_request(OP_INSERT, 0, VAL_MIN);
    send_request(OP_INSERT, 1, VAL_MAX);
    send_request(OP_INSERT, 1, 0);
    send_request(OP_INSERT, 0, 32'hffff_ffff);  // list: -1, min, 0, max
    send_request(OP_READ,   0, 0);
    send_request(OP_READ,   3, 0);
    send_request(OP_READ,   4, 0);         // one past the last entry
    send_request(OP_READ,   31, 0);        // every index bit set
    send_request(OP_LOCATE, 0, 0);
    send_request(OP_LOCATE, 0, 5);         // value not present
    send_request(OP_PREV,   0, 32'hffff_ffff);  // match at the head
    send_request(OP_PREV,   0, VAL_MAX);
    send_request(OP_NEXT,   0, VAL_MAX);   // match at the tail
    send_request(OP_NEXT,   0, 32'hffff_ffff);
    send_request(OP_DELETE, 1, 0);
    send_request(OP_DELETE, 16, 0);        // out of range
    send_request(OP_UNUSED, 31, VAL_MAX);  // unused code does nothing
    send_request(OP_CLEAR,  0, 0);
    send_request(OP_READ,   0, 0);         // entries kept, but list is empty

    // Fill to capacity, try one more insert, then work at the top end.
    for (int i = 0; i < LIST_DEPTH + 1; i++)
      send_request(OP_INSERT, IdxW'($urandom_range(0, fill_level)),
                   pick_insert_value());
    send_request(OP_READ,   IdxW'(LIST_DEPTH - 1), 0);
    send_request(OP_READ,   IdxW'(LIST_DEPTH), 0);
    send_request(OP_LOCATE, 0, pick_key());
    send_request(OP_DELETE, IdxW'(LIST_DEPTH), 0);
    send_request(OP_DELETE, IdxW'($urandom_range(0, LIST_DEPTH - 1)), 0);

    // Hold the sender until everything in flight has come back.
    drain_results();

    // Random bursts that grow, shrink or churn the list. One burst in four
    // runs with no gaps on either side, and every fifth waits for the
    // results to drain first.
    for (int b = 0; b < 14; b++) begin
      if (b % 5 == 4) drain_results();
      quiet = ($urandom_range(0, 3) == 0);
      kind  = $urandom_range(0, 2);
      case (kind)
        0:       run_burst(50, 8, 40);
        1:       run_burst(10, 45, 40);
        default: run_burst(25, 20, 40);
      endcase
    end
    quiet = 1'b0;

    // Wait for the last results, then keep the clock running to catch stray ones.
    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
